[hw/rtl/bmprle_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmprle_pkg
// Shared types and codes for the BMP RLE8/RLE4 span decoder: request and
// response payloads, configuration set, operation and escape codes.
// ----------------------------------------------------------------------------
package bmprle_pkg;

   localparam int MAX_DIM_DEF       = 4096;
   localparam int PALETTE_DEPTH_DEF = 256;

   localparam logic [1:0] OP_DATA = 2'd0;
   localparam logic [1:0] OP_PAL  = 2'd1;
   localparam logic [1:0] OP_NEW  = 2'd2;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_NIBBLE = 2'd2;
   localparam logic [1:0] CSR_BYTES  = 2'd3;

   localparam logic [7:0] ESC_EOL   = 8'd0;
   localparam logic [7:0] ESC_EOB   = 8'd1;
   localparam logic [7:0] ESC_DELTA = 8'd2;

   localparam logic KIND_SPAN = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  data_byte;
      logic [7:0]  palette_index;
      logic [23:0] palette_color;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [11:0] x_start;
      logic [11:0] row;
      logic [7:0]  span_length;
      logic [23:0] color_even;
      logic [23:0] color_odd;
   } rsp_type;

   typedef struct packed {
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic        nibble_mode;
      logic [31:0] compressed_bytes;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  data_byte;
      logic [23:0] color_a;
      logic [23:0] color_b;
   } item_type;

endpackage

[hw/rtl/bmprle_palette.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmprle_palette
// Palette memory: one write port, two registered read ports addressed from
// the incoming stream byte (full byte or high nibble, and low nibble).
// ----------------------------------------------------------------------------
module bmprle_palette #(
   parameter int PALETTE_DEPTH = bmprle_pkg::PALETTE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [7:0]  wr_idx,
   input  logic [23:0] wr_color,
   input  logic        rd_en,
   input  logic [7:0]  rd_byte,
   input  logic        nibble_mode,
   output logic [23:0] color_a,
   output logic [23:0] color_b
);
   import bmprle_pkg::*;

   localparam int AW = $clog2(PALETTE_DEPTH);

   logic [23:0] mem [PALETTE_DEPTH];
   logic [7:0]  addr_a;
   logic        a_ok;
   logic        w_ok;
   logic [23:0] color_a_ff;
   logic [23:0] color_b_ff;

   assign addr_a = nibble_mode ? {4'd0, rd_byte[7:4]} : rd_byte;
   assign a_ok   = int'(addr_a) < PALETTE_DEPTH;
   assign w_ok   = int'(wr_idx) < PALETTE_DEPTH;

   always_ff @(posedge clock) begin
      if (wr_en && w_ok) begin
         mem[wr_idx[AW-1:0]] <= wr_color;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         color_a_ff <= a_ok ? mem[addr_a[AW-1:0]] : '0;
         color_b_ff <= mem[AW'(rd_byte[3:0])];
      end
   end

   assign color_a = color_a_ff;
   assign color_b = color_b_ff;

endmodule

[hw/rtl/bmprle_parse.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmprle_parse
// Stream parser: holds the decode state and turns one registered request
// into at most one span or end-of-image response.
// ----------------------------------------------------------------------------
module bmprle_parse #(
   parameter int MAX_DIM = bmprle_pkg::MAX_DIM_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bmprle_pkg::cfg_type  cfg,
   input  bmprle_pkg::item_type item,
   input  logic                 advance,
   output logic                 res_valid,
   output bmprle_pkg::rsp_type  res_data
);
   import bmprle_pkg::*;

   localparam int POS_W = $clog2(MAX_DIM + 1);
   localparam int SUM_W = ((POS_W > 8) ? POS_W : 8) + 1;

   typedef enum logic [2:0] {
      PH_CODE,
      PH_SECOND,
      PH_DX,
      PH_DY,
      PH_LIT,
      PH_PAD
   } phase_type;

   function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W-1:0] a,
                                                input logic [7:0] b);
      logic [SUM_W-1:0] s;
      s = SUM_W'(a) + SUM_W'(b);
      return (s > SUM_W'(MAX_DIM)) ? POS_W'(MAX_DIM) : POS_W'(s);
   endfunction

   phase_type        phase_ff, phase_in;
   logic [7:0]       run_ff, run_in;
   logic [7:0]       lit_ff, lit_in;
   logic             pad_ff, pad_in;
   logic [7:0]       dx_ff, dx_in;
   logic [POS_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic [31:0]      bytes_ff, bytes_in;
   logic             done_ff, done_in;

   logic             span_do;
   logic [7:0]       span_n;
   logic [23:0]      span_ce;
   logic [23:0]      span_co;
   logic [POS_W-1:0] ew;
   logic [POS_W-1:0] eh;
   logic [POS_W-1:0] room;
   logic [7:0]       len;
   logic [8:0]       b_inc;
   logic [7:0]       b;

   assign b     = item.data_byte;
   assign b_inc = {1'b0, b} + 9'd1;
   assign ew    = (32'(cfg.image_width) > 32'(MAX_DIM)) ? POS_W'(MAX_DIM)
                                                        : POS_W'(cfg.image_width);
   assign eh    = (32'(cfg.image_height) > 32'(MAX_DIM)) ? POS_W'(MAX_DIM)
                                                         : POS_W'(cfg.image_height);
   assign room  = ew - col_ff;
   assign len   = (32'(span_n) < 32'(room)) ? span_n : 8'(room);

   always_comb begin
      phase_in  = phase_ff;
      run_in    = run_ff;
      lit_in    = lit_ff;
      pad_in    = pad_ff;
      dx_in     = dx_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      bytes_in  = bytes_ff;
      done_in   = done_ff;
      res_valid = 1'b0;
      res_data  = '0;
      span_do   = 1'b0;
      span_n    = '0;
      span_ce   = '0;
      span_co   = '0;

      unique case (item.op)
         OP_NEW: begin
            phase_in = PH_CODE;
            run_in   = '0;
            lit_in   = '0;
            pad_in   = 1'b0;
            dx_in    = '0;
            col_in   = '0;
            row_in   = '0;
            bytes_in = '0;
            done_in  = 1'b0;
         end
         OP_DATA: begin
            if (!done_ff) begin
               if (phase_ff == PH_CODE && bytes_ff >= cfg.compressed_bytes) begin
                  done_in       = 1'b1;
                  phase_in      = PH_CODE;
                  res_valid     = 1'b1;
                  res_data.kind = KIND_END;
               end else begin
                  if (bytes_ff != '1) begin
                     bytes_in = bytes_ff + 32'd1;
                  end
                  unique case (phase_ff)
                     PH_CODE: begin
                        run_in   = b;
                        phase_in = PH_SECOND;
                     end
                     PH_SECOND: begin
                        priority if (run_ff != '0) begin
                           phase_in = PH_CODE;
                           span_do  = 1'b1;
                           span_n   = run_ff;
                           span_ce  = item.color_a;
                           span_co  = cfg.nibble_mode ? item.color_b : item.color_a;
                        end else if (b == ESC_EOL) begin
                           col_in   = '0;
                           row_in   = sat_pos(row_ff, 8'd1);
                           phase_in = PH_CODE;
                        end else if (b == ESC_EOB) begin
                           done_in       = 1'b1;
                           phase_in      = PH_CODE;
                           res_valid     = 1'b1;
                           res_data.kind = KIND_END;
                        end else if (b == ESC_DELTA) begin
                           phase_in = PH_DX;
                        end else begin
                           lit_in   = b;
                           pad_in   = cfg.nibble_mode ? b_inc[1] : b[0];
                           phase_in = PH_LIT;
                        end
                     end
                     PH_DX: begin
                        dx_in    = b;
                        phase_in = PH_DY;
                     end
                     PH_DY: begin
                        col_in   = sat_pos(col_ff, dx_ff);
                        row_in   = sat_pos(row_ff, b);
                        phase_in = PH_CODE;
                     end
                     PH_LIT: begin
                        span_do = 1'b1;
                        span_ce = item.color_a;
                        if (cfg.nibble_mode) begin
                           span_n  = (lit_ff >= 8'd2) ? 8'd2 : lit_ff;
                           span_co = (span_n == 8'd2) ? item.color_b : '0;
                        end else begin
                           span_n  = (lit_ff >= 8'd1) ? 8'd1 : 8'd0;
                           span_co = item.color_a;
                        end
                        lit_in = lit_ff - span_n;
                        if (lit_in == '0) begin
                           phase_in = pad_ff ? PH_PAD : PH_CODE;
                        end
                     end
                     PH_PAD: begin
                        pad_in   = 1'b0;
                        phase_in = PH_CODE;
                     end
                     default: begin
                        pad_in   = 1'b0;
                        phase_in = PH_CODE;
                     end
                  endcase
               end
            end
         end
         default: begin
         end
      endcase

      if (span_do) begin
         if (row_ff < eh && col_ff < ew && span_n != '0) begin
            res_valid            = 1'b1;
            res_data.kind        = KIND_SPAN;
            res_data.x_start     = 12'(col_ff);
            res_data.row         = 12'(row_ff);
            res_data.span_length = len;
            res_data.color_even  = span_ce;
            res_data.color_odd   = span_co;
         end
         col_in = sat_pos(col_ff, span_n);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CODE;
         run_ff   <= '0;
         lit_ff   <= '0;
         pad_ff   <= 1'b0;
         dx_ff    <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         bytes_ff <= '0;
         done_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         run_ff   <= run_in;
         lit_ff   <= lit_in;
         pad_ff   <= pad_in;
         dx_ff    <= dx_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         bytes_ff <= bytes_in;
         done_ff  <= done_in;
      end
   end

endmodule

[hw/rtl/bmp_rle_span_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_rle_span_decoder
// Decodes a BMP RLE8/RLE4 byte stream into palette-colored pixel spans.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  op, byte, palette write
//   rsp_      out        rsp_valid/rsp_stall  span or end of image
//   csr_      in         csr_we               index, 32-bit write data
//
// One request per cycle unless stalled. Palette read and request registered at
// acceptance; parse and clip from those registers into the response register.
// Reset clears parse state and resets configuration; palette is not cleared.
// A stalled response holds the parse stage, which then stalls requests.
// ----------------------------------------------------------------------------
module bmp_rle_span_decoder #(
   parameter int MAX_DIM       = bmprle_pkg::MAX_DIM_DEF,
   parameter int PALETTE_DEPTH = bmprle_pkg::PALETTE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bmprle_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bmprle_pkg::rsp_type rsp_data,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata
);
   import bmprle_pkg::*;

   cfg_type  cfg_ff;
   logic     s1_valid_ff;
   logic [1:0] s1_op_ff;
   logic [7:0] s1_byte_ff;
   item_type item;
   logic     accept;
   logic     slot_free;
   logic     advance;
   logic     res_valid;
   rsp_type  res_data;
   logic     rsp_valid_ff;
   rsp_type  rsp_data_ff;
   logic [23:0] color_a;
   logic [23:0] color_b;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !slot_free;
   assign accept    = req_valid && !req_stall;
   assign advance   = s1_valid_ff && slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width      <= 13'd1;
         cfg_ff.image_height     <= 13'd1;
         cfg_ff.nibble_mode      <= 1'b0;
         cfg_ff.compressed_bytes <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH:  cfg_ff.image_width      <= csr_wdata[12:0];
            CSR_HEIGHT: cfg_ff.image_height     <= csr_wdata[12:0];
            CSR_NIBBLE: cfg_ff.nibble_mode      <= csr_wdata[0];
            CSR_BYTES:  cfg_ff.compressed_bytes <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   bmprle_palette #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_palette (
      .clock       (clock),
      .wr_en       (accept && req_data.op == OP_PAL),
      .wr_idx      (req_data.palette_index),
      .wr_color    (req_data.palette_color),
      .rd_en       (accept),
      .rd_byte     (req_data.data_byte),
      .nibble_mode (cfg_ff.nibble_mode),
      .color_a     (color_a),
      .color_b     (color_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff   <= req_data.op;
         s1_byte_ff <= req_data.data_byte;
      end
   end

   assign item.op        = s1_op_ff;
   assign item.data_byte = s1_byte_ff;
   assign item.color_a   = color_a;
   assign item.color_b   = color_b;

   bmprle_parse #(
      .MAX_DIM(MAX_DIM)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .item      (item),
      .advance   (advance),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (slot_free) begin
         rsp_valid_ff <= advance && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
